// ----- hdl/assert_macros.svh -----
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define SPV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also covers the reset cycles.
`define SPV_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- hdl/spv_pkg.sv -----
// ----------------------------------------------------------------------------
// spv_pkg
// Types and codes shared by the sampler voice controller, datapath and top.
// ----------------------------------------------------------------------------
package spv_pkg;

    // Item opcodes
    localparam logic [2:0] OPC_TICK      = 3'd0;
    localparam logic [2:0] OPC_START     = 3'd1;
    localparam logic [2:0] OPC_STOP_TAIL = 3'd2;
    localparam logic [2:0] OPC_STOP_NOW  = 3'd3;
    localparam logic [2:0] OPC_WRITE     = 3'd4;

    // Register indexes
    localparam logic [2:0] REG_FILTER_ENABLE = 3'd0;
    localparam logic [2:0] REG_COEF_B0       = 3'd1;
    localparam logic [2:0] REG_COEF_B1       = 3'd2;
    localparam logic [2:0] REG_COEF_B2       = 3'd3;
    localparam logic [2:0] REG_COEF_A1       = 3'd4;
    localparam logic [2:0] REG_COEF_A2       = 3'd5;
    localparam logic [2:0] REG_SOURCE_STEREO = 3'd6;
    localparam logic [2:0] REG_OUTPUT_STEREO = 3'd7;

    // Sequencer steps; also the datapath command code
    localparam logic [4:0] SEQ_IDLE       = 5'd0;
    localparam logic [4:0] SEQ_MOD_LOAD   = 5'd1;
    localparam logic [4:0] SEQ_MOD_STEP   = 5'd2;
    localparam logic [4:0] SEQ_WRITE      = 5'd3;
    localparam logic [4:0] SEQ_READ0      = 5'd4;
    localparam logic [4:0] SEQ_READ1      = 5'd5;
    localparam logic [4:0] SEQ_INT_MUL    = 5'd6;
    localparam logic [4:0] SEQ_INT_ROUND  = 5'd7;
    localparam logic [4:0] SEQ_GAIN_MUL   = 5'd8;
    localparam logic [4:0] SEQ_GAIN_ROUND = 5'd9;
    localparam logic [4:0] SEQ_ENV_MUL    = 5'd10;
    localparam logic [4:0] SEQ_ENV_ROUND  = 5'd11;
    localparam logic [4:0] SEQ_ENV        = 5'd12;
    localparam logic [4:0] SEQ_MIX        = 5'd13;
    localparam logic [4:0] SEQ_FILT0      = 5'd14;
    localparam logic [4:0] SEQ_FILT1      = 5'd15;
    localparam logic [4:0] SEQ_FILT2      = 5'd16;
    localparam logic [4:0] SEQ_FILT3      = 5'd17;
    localparam logic [4:0] SEQ_FILT4      = 5'd18;
    localparam logic [4:0] SEQ_FILT5      = 5'd19;
    localparam logic [4:0] SEQ_OUT        = 5'd20;
    localparam logic [4:0] SEQ_ZERO       = 5'd21;
    localparam logic [4:0] SEQ_START      = 5'd22;

    localparam logic [16:0] FULL_LEVEL = 17'd32768;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [23:0]        pitch_step;
        logic [15:0]        note_gain;
        logic [15:0]        start_position;
        logic [15:0]        end_position;
        logic [15:0]        attack_step;
        logic [15:0]        release_step;
        logic [15:0]        sample_address;
        logic signed [15:0] sample_left;
        logic signed [15:0] sample_right;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
        logic               voice_active;
    } out_item_t;

    typedef struct packed {
        logic               filter_enable;
        logic signed [17:0] coef_b0;
        logic signed [17:0] coef_b1;
        logic signed [17:0] coef_b2;
        logic signed [17:0] coef_a1;
        logic signed [17:0] coef_a2;
        logic               source_stereo;
        logic               output_stereo;
    } cfg_t;

    typedef struct packed {
        logic [4:0] op;
        logic       capture;
        logic       sel_wr;
        logic       attack;
        logic       release_on;
    } cmd_t;

    typedef struct packed {
        logic mod_last;
        logic env_full;
        logic env_empty;
        logic past_end;
    } status_t;

endpackage

// ----- hdl/spv_ctrl.sv -----
// ----------------------------------------------------------------------------
// spv_ctrl
// Sequencer for the sampler voice: handshakes, voice phase flags, step order.
// ----------------------------------------------------------------------------
module spv_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [2:0]       s_opcode,
    input  logic             s_attack_nz,
    output logic             m_valid,
    input  logic             m_ready,
    input  spv_pkg::cfg_t    cfg,
    input  spv_pkg::status_t status,
    output spv_pkg::cmd_t    cmd
);
    import spv_pkg::*;

    logic [4:0] state_reg, state_next;
    logic       on_reg, on_next;
    logic       attack_reg, attack_next;
    logic       release_reg, release_next;
    logic       wr_reg, wr_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free, out_step, load_out;

    assign out_free = !m_valid_reg || m_ready;
    assign out_step = (state_reg == SEQ_OUT) || (state_reg == SEQ_ZERO);
    assign load_out = out_step && out_free;
    assign s_ready  = (state_reg == SEQ_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        on_next      = on_reg;
        attack_next  = attack_reg;
        release_next = release_reg;
        wr_next      = wr_reg;
        case (state_reg)
            SEQ_IDLE: begin
                if (s_valid) begin
                    case (s_opcode)
                        OPC_TICK: begin
                            wr_next    = 1'b0;
                            state_next = on_reg ? SEQ_MOD_LOAD : SEQ_ZERO;
                        end
                        OPC_START: begin
                            on_next      = 1'b1;
                            attack_next  = s_attack_nz;
                            release_next = 1'b0;
                            state_next   = SEQ_START;
                        end
                        OPC_STOP_TAIL: begin
                            if (on_reg) begin
                                attack_next  = 1'b0;
                                release_next = 1'b1;
                            end
                        end
                        OPC_STOP_NOW: begin
                            on_next      = 1'b0;
                            attack_next  = 1'b0;
                            release_next = 1'b0;
                        end
                        OPC_WRITE: begin
                            wr_next    = 1'b1;
                            state_next = SEQ_MOD_LOAD;
                        end
                        default: ;
                    endcase
                end
            end
            SEQ_MOD_LOAD:   state_next = SEQ_MOD_STEP;
            SEQ_MOD_STEP: begin
                if (status.mod_last) begin
                    state_next = wr_reg ? SEQ_WRITE : SEQ_READ0;
                end
            end
            SEQ_WRITE:      state_next = SEQ_IDLE;
            SEQ_READ0:      state_next = SEQ_READ1;
            SEQ_READ1:      state_next = SEQ_INT_MUL;
            SEQ_INT_MUL:    state_next = SEQ_INT_ROUND;
            SEQ_INT_ROUND:  state_next = SEQ_GAIN_MUL;
            SEQ_GAIN_MUL:   state_next = SEQ_GAIN_ROUND;
            SEQ_GAIN_ROUND: state_next = SEQ_ENV_MUL;
            SEQ_ENV_MUL:    state_next = SEQ_ENV_ROUND;
            SEQ_ENV_ROUND:  state_next = SEQ_ENV;
            SEQ_ENV: begin
                if (release_reg && status.env_empty) begin
                    on_next      = 1'b0;
                    release_next = 1'b0;
                    state_next   = SEQ_ZERO;
                end else begin
                    if (attack_reg && status.env_full) begin
                        attack_next = 1'b0;
                    end
                    if (!cfg.output_stereo) begin
                        state_next = SEQ_MIX;
                    end else begin
                        state_next = cfg.filter_enable ? SEQ_FILT0 : SEQ_OUT;
                    end
                end
            end
            SEQ_MIX:   state_next = cfg.filter_enable ? SEQ_FILT0 : SEQ_OUT;
            SEQ_FILT0: state_next = SEQ_FILT1;
            SEQ_FILT1: state_next = SEQ_FILT2;
            SEQ_FILT2: state_next = SEQ_FILT3;
            SEQ_FILT3: state_next = SEQ_FILT4;
            SEQ_FILT4: state_next = SEQ_FILT5;
            SEQ_FILT5: state_next = SEQ_OUT;
            SEQ_OUT: begin
                if (out_free) begin
                    if (status.past_end) begin
                        on_next      = 1'b0;
                        attack_next  = 1'b0;
                        release_next = 1'b0;
                    end
                    state_next = SEQ_IDLE;
                end
            end
            SEQ_ZERO: begin
                if (out_free) begin
                    state_next = SEQ_IDLE;
                end
            end
            SEQ_START: state_next = SEQ_IDLE;
            default:   state_next = SEQ_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_comb begin
        cmd.op         = (out_step && !out_free) ? SEQ_IDLE : state_reg;
        cmd.capture    = s_valid && s_ready;
        cmd.sel_wr     = wr_reg;
        cmd.attack     = attack_reg;
        cmd.release_on = release_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SEQ_IDLE;
            on_reg      <= 1'b0;
            attack_reg  <= 1'b0;
            release_reg <= 1'b0;
            wr_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            on_reg      <= on_next;
            attack_reg  <= attack_next;
            release_reg <= release_next;
            wr_reg      <= wr_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- hdl/spv_dp.sv -----
// ----------------------------------------------------------------------------
// spv_dp
// Sampler voice datapath: sample stores, index reduction, one multiplier per
// channel shared by interpolation, gain, envelope and biquad, result register.
// ----------------------------------------------------------------------------
module spv_dp #(
    parameter int SAMPLE_DEPTH = 65536
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  spv_pkg::in_item_t  s_data,
    input  spv_pkg::cfg_t      cfg,
    input  spv_pkg::cmd_t      cmd,
    output spv_pkg::status_t   status,
    output spv_pkg::out_item_t m_data
);
    import spv_pkg::*;

    localparam int AW        = $clog2(SAMPLE_DEPTH);
    localparam int MOD_STEPS = (SAMPLE_DEPTH > 65536) ? 1 : $clog2(131072 / SAMPLE_DEPTH);
    localparam int KW        = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

    localparam logic signed [41:0] MEM_HI = 42'sh07FFFFFFFFF;
    localparam logic signed [41:0] MEM_LO = -42'sh08000000000;

    function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
        logic signed [39:0] r;
        if (v > MEM_HI) begin
            r = 40'sh7FFFFFFFFF;
        end else if (v < MEM_LO) begin
            r = 40'sh8000000000;
        end else begin
            r = v[39:0];
        end
        return r;
    endfunction

    function automatic logic [16:0] sat_level(input logic [15:0] v);
        return ({1'b0, v} > FULL_LEVEL) ? FULL_LEVEL : {1'b0, v};
    endfunction

    logic signed [15:0] left_mem  [SAMPLE_DEPTH];
    logic signed [15:0] right_mem [SAMPLE_DEPTH];

    in_item_t           in_reg;
    out_item_t          m_data_reg;
    logic [16:0]        mod_reg;
    logic [KW-1:0]      k_reg;
    logic signed [15:0] rd_l_reg, rd_r_reg;
    logic signed [15:0] s0_reg   [2];
    logic signed [35:0] prod_reg [2];
    logic signed [16:0] x_reg    [2];
    logic signed [15:0] y_reg    [2];
    logic signed [41:0] acc_reg  [2];
    logic signed [39:0] v1_reg   [2];
    logic signed [39:0] v2_reg   [2];
    logic [31:0]        pos_reg;
    logic [15:0]        end_reg;
    logic [23:0]        step_reg;
    logic [16:0]        gain_reg, env_reg, rise_reg, fall_reg;

    logic [31:0]        mod_div;
    logic               mod_ge;
    logic [AW-1:0]      idx0, idx1, rd_addr;
    logic [AW:0]        idx1_wide;
    logic               rd_en;
    logic signed [15:0] samp  [2];
    logic signed [17:0] mul_a [2];
    logic signed [17:0] mul_b [2];
    logic signed [37:0] isum  [2];
    logic signed [36:0] gsum  [2];
    logic signed [41:0] ysum  [2];
    logic signed [25:0] yq    [2];
    logic signed [15:0] ysat  [2];
    logic signed [41:0] vdiff [2];
    logic signed [17:0] msum;
    logic [17:0]        env_sum;
    logic [32:0]        pos_sum;
    logic [16:0]        fall_sat;
    logic signed [15:0] out_l, out_r;

    // Index reduction: one conditional subtract of a shifted depth per step
    assign mod_div   = 32'(SAMPLE_DEPTH) << k_reg;
    assign mod_ge    = {15'd0, mod_reg} >= mod_div;
    assign idx0      = AW'(mod_reg);
    assign idx1_wide = {1'b0, idx0} + (AW + 1)'(1);
    assign idx1      = (idx1_wide == (AW + 1)'(SAMPLE_DEPTH)) ? '0 : idx1_wide[AW-1:0];
    assign rd_en     = (cmd.op == SEQ_READ0) || (cmd.op == SEQ_READ1);
    assign rd_addr   = (cmd.op == SEQ_READ1) ? idx1 : idx0;

    assign env_sum  = {1'b0, env_reg} + {1'b0, rise_reg};
    assign pos_sum  = {1'b0, pos_reg} + 33'(step_reg);
    assign msum     = 18'(x_reg[0]) + 18'(x_reg[1]) + 18'sd1;
    assign fall_sat = sat_level(in_reg.release_step);

    assign status.mod_last  = (k_reg == '0);
    assign status.env_full  = env_sum >= {1'b0, FULL_LEVEL};
    assign status.env_empty = env_reg <= fall_reg;
    assign status.past_end  = pos_sum > {1'b0, end_reg, 16'd0};

    assign out_l  = cfg.filter_enable ? y_reg[0] : x_reg[0][15:0];
    assign out_r  = !cfg.output_stereo ? out_l :
                    (cfg.filter_enable ? y_reg[1] : x_reg[1][15:0]);
    assign m_data = m_data_reg;

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            samp[c]  = (c == 0 || !cfg.source_stereo) ? rd_l_reg : rd_r_reg;
            mul_a[c] = '0;
            mul_b[c] = '0;
            case (cmd.op)
                SEQ_INT_MUL: begin
                    mul_a[c] = 18'(samp[c]) - 18'(s0_reg[c]);
                    mul_b[c] = {2'b00, pos_reg[15:0]};
                end
                SEQ_GAIN_MUL: begin
                    mul_a[c] = 18'(x_reg[c]);
                    mul_b[c] = {1'b0, gain_reg};
                end
                SEQ_ENV_MUL: begin
                    mul_a[c] = 18'(x_reg[c]);
                    mul_b[c] = {1'b0, env_reg};
                end
                SEQ_FILT0: begin
                    mul_a[c] = cfg.coef_b0;
                    mul_b[c] = 18'(x_reg[c]);
                end
                SEQ_FILT1: begin
                    mul_a[c] = cfg.coef_b1;
                    mul_b[c] = 18'(x_reg[c]);
                end
                SEQ_FILT2: begin
                    mul_a[c] = cfg.coef_a1;
                    mul_b[c] = 18'(y_reg[c]);
                end
                SEQ_FILT3: begin
                    mul_a[c] = cfg.coef_b2;
                    mul_b[c] = 18'(x_reg[c]);
                end
                SEQ_FILT4: begin
                    mul_a[c] = cfg.coef_a2;
                    mul_b[c] = 18'(y_reg[c]);
                end
                default: ;
            endcase
            // Round half up: add half an LSB, then take the upper bits
            isum[c]  = (38'(s0_reg[c]) <<< 16) + 38'(prod_reg[c]) + 38'sd32768;
            gsum[c]  = 37'(prod_reg[c]) + 37'sd16384;
            ysum[c]  = 42'(prod_reg[c]) + 42'(v1_reg[c]) + 42'sd32768;
            yq[c]    = ysum[c][41:16];
            if (yq[c] > 26'sd32767) begin
                ysat[c] = 16'sh7FFF;
            end else if (yq[c] < -26'sd32768) begin
                ysat[c] = 16'sh8000;
            end else begin
                ysat[c] = yq[c][15:0];
            end
            vdiff[c] = acc_reg[c] - 42'(prod_reg[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == SEQ_WRITE) begin
            left_mem[idx0] <= in_reg.sample_left;
        end
        if (rd_en) begin
            rd_l_reg <= left_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == SEQ_WRITE) begin
            right_mem[idx0] <= in_reg.sample_right;
        end
        if (rd_en) begin
            rd_r_reg <= right_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
        case (cmd.op)
            SEQ_MOD_LOAD: begin
                mod_reg <= cmd.sel_wr ? {1'b0, in_reg.sample_address} : {1'b0, pos_reg[31:16]};
                k_reg   <= KW'(MOD_STEPS - 1);
            end
            SEQ_MOD_STEP: begin
                if (mod_ge) begin
                    mod_reg <= 17'({15'd0, mod_reg} - mod_div);
                end
                k_reg <= k_reg - KW'(1);
            end
            SEQ_MIX: x_reg[0] <= msum[17:1];
            SEQ_OUT: begin
                m_data_reg.out_left     <= out_l;
                m_data_reg.out_right    <= out_r;
                m_data_reg.voice_active <= !status.past_end;
            end
            SEQ_ZERO: m_data_reg <= '0;
            default: ;
        endcase
        for (int c = 0; c < 2; c++) begin
            prod_reg[c] <= mul_a[c] * mul_b[c];
            case (cmd.op)
                SEQ_READ1:      s0_reg[c]  <= samp[c];
                SEQ_INT_ROUND:  x_reg[c]   <= isum[c][32:16];
                SEQ_GAIN_ROUND: x_reg[c]   <= gsum[c][31:15];
                SEQ_ENV_ROUND:  x_reg[c]   <= gsum[c][31:15];
                SEQ_FILT1:      y_reg[c]   <= ysat[c];
                SEQ_FILT2:      acc_reg[c] <= 42'(prod_reg[c]) + 42'(v2_reg[c]);
                SEQ_FILT4:      acc_reg[c] <= 42'(prod_reg[c]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            end_reg  <= '0;
            step_reg <= '0;
            gain_reg <= '0;
            env_reg  <= '0;
            rise_reg <= '0;
            fall_reg <= '0;
            for (int c = 0; c < 2; c++) begin
                v1_reg[c] <= '0;
                v2_reg[c] <= '0;
            end
        end else begin
            case (cmd.op)
                SEQ_START: begin
                    pos_reg  <= {in_reg.start_position, 16'd0};
                    end_reg  <= in_reg.end_position;
                    step_reg <= in_reg.pitch_step;
                    gain_reg <= sat_level(in_reg.note_gain);
                    rise_reg <= sat_level(in_reg.attack_step);
                    fall_reg <= (fall_sat == '0) ? FULL_LEVEL : fall_sat;
                    env_reg  <= (in_reg.attack_step != '0) ? '0 : FULL_LEVEL;
                    for (int c = 0; c < 2; c++) begin
                        v1_reg[c] <= '0;
                        v2_reg[c] <= '0;
                    end
                end
                SEQ_ENV: begin
                    if (cmd.attack) begin
                        env_reg <= status.env_full ? FULL_LEVEL : env_sum[16:0];
                    end else if (cmd.release_on) begin
                        env_reg <= status.env_empty ? '0 : env_reg - fall_reg;
                    end
                end
                SEQ_FILT3: begin
                    for (int c = 0; c < 2; c++) begin
                        if (c == 0 || cfg.output_stereo) begin
                            v1_reg[c] <= sat40(vdiff[c]);
                        end
                    end
                end
                SEQ_FILT5: begin
                    for (int c = 0; c < 2; c++) begin
                        if (c == 0 || cfg.output_stereo) begin
                            v2_reg[c] <= sat40(vdiff[c]);
                        end
                    end
                end
                SEQ_OUT: pos_reg <= pos_sum[32] ? '1 : pos_sum[31:0];
                default: ;
            endcase
        end
    end

endmodule

// ----- hdl/sample_playback_voice_top.sv -----
// ----------------------------------------------------------------------------
// sample_playback_voice_top
// One wavetable sampler voice with linear interpolation, gain, envelope and
// a per-channel biquad.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one beat per item (tick, start, stop with tail, stop now,
//   sample write). Only a tick produces a result beat on the m_* channel.
//   cfg_* channel: register writes, always ready; write only while idle.
//   Steps per beat, set by the sequencer stepping one shared multiplier per
//   channel: a tick runs MOD_STEPS index steps (MOD_STEPS = 1 at a depth of
//   65536), two sample reads, interpolation, gain and envelope multiply and
//   round, envelope update and output, a mix step in mono output and the
//   biquad steps when on; an idle tick only the output step; a sample write
//   the index steps and write; start a load step. Stores use one memory port
//   each, so the two interpolation samples are read on consecutive cycles.
//   MOD_STEPS is the number of subtract steps that wrap an index into
//   SAMPLE_DEPTH: 1 for depths above 65536, log2(131072 / depth) otherwise.
//   Reset: voice idle, registers to defaults, result register empty.
//   Sample stores are not cleared; read only entries written before.
//   Receiver stall: the result holds in the output register; a new item is
//   still taken, and the next tick waits at its last step until it drains.
// ----------------------------------------------------------------------------
module sample_playback_voice_top #(
    parameter int SAMPLE_DEPTH = 65536
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  spv_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output spv_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [17:0]        cfg_data
);
    import spv_pkg::*;

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;

    // Register file: always accept a write beat
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.filter_enable <= 1'b0;
            cfg_reg.coef_b0       <= 18'sd65536;
            cfg_reg.coef_b1       <= '0;
            cfg_reg.coef_b2       <= '0;
            cfg_reg.coef_a1       <= '0;
            cfg_reg.coef_a2       <= '0;
            cfg_reg.source_stereo <= 1'b0;
            cfg_reg.output_stereo <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FILTER_ENABLE: cfg_reg.filter_enable <= cfg_data[0];
                REG_COEF_B0:       cfg_reg.coef_b0       <= cfg_data;
                REG_COEF_B1:       cfg_reg.coef_b1       <= cfg_data;
                REG_COEF_B2:       cfg_reg.coef_b2       <= cfg_data;
                REG_COEF_A1:       cfg_reg.coef_a1       <= cfg_data;
                REG_COEF_A2:       cfg_reg.coef_a2       <= cfg_data;
                REG_SOURCE_STEREO: cfg_reg.source_stereo <= cfg_data[0];
                REG_OUTPUT_STEREO: cfg_reg.output_stereo <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer: owns the item and result handshakes and the voice phase flags
    spv_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_data.opcode),
        .s_attack_nz (s_data.attack_step != '0),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cfg         (cfg_reg),
        .status      (status),
        .cmd         (cmd)
    );

    // Datapath: stores, arithmetic and the result register
    spv_dp #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .cmd     (cmd),
        .status  (status),
        .m_data  (m_data)
    );

endmodule

// ----- hdl/spv_chk.sv -----
// ----------------------------------------------------------------------------
// spv_chk
// Port-level checks for the sampler voice, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spv_chk (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input spv_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input spv_pkg::out_item_t m_data,
    input logic               cfg_ready
);
    import spv_pkg::*;

    // Reset empties the result register
    `SPV_ASSERT_ALWAYS(a_reset_empties_out, !aresetn |=> !m_valid, "result valid after reset")

    // A stalled result holds
    `SPV_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled result changed")

    // A tick or a sample write keeps the sequencer busy on the next cycle
    `SPV_ASSERT(a_busy_after_item, s_valid && s_ready && (s_data.opcode == OPC_TICK || s_data.opcode == OPC_WRITE) |=> !s_ready, "ready right after tick or write")

    // Register writes are never held off
    `SPV_ASSERT(a_cfg_ready, cfg_ready, "config port not ready")

endmodule

bind sample_playback_voice_top spv_chk u_spv_chk (.*);

// ----- bench/sample_playback_voice_top_tb.sv -----
// ----------------------------------------------------------------------------
// sample_playback_voice_top_tb
// Self-checking bench for one sampler voice. Drives sample writes, note
// starts, stops and ticks with random burst gaps and receiver stalls, predicts
// every tick beat in a bit-exact scoreboard and compares it field by field.
// ----------------------------------------------------------------------------
module sample_playback_voice_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import spv_pkg::*;

    localparam int  STORE_SPAN = 256;   // addresses used by played regions
    localparam longint MEM_HI = 64'sd549755813887;
    localparam int  IN_W = $bits(in_item_t);

    // Scoreboard: voice state copy, register copy, queue of predicted ticks.
    class voice_scoreboard;
        logic signed [15:0] lstore [int];
        logic signed [15:0] rstore [int];
        logic [31:0] pos;
        logic [15:0] endp;
        logic [23:0] pstep;
        longint gain, level, rise, fall;
        bit on, attack, release_on;
        longint fmem [4];
        cfg_t cfg;
        out_item_t tick_queue [$];
        int errors;

        function new();
            cfg = '0;
            cfg.coef_b0 = 18'sd65536;
            cfg.output_stereo = 1'b1;
            pos = 0; endp = 0; pstep = 0;
            gain = 0; level = 0; rise = 0; fall = 0;
            on = 0; attack = 0; release_on = 0;
            foreach (fmem[i]) fmem[i] = 0;
            errors = 0;
        endfunction

        function longint rnd_shift(longint v, int n);
            return (v + (longint'(1) <<< (n - 1))) >>> n;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint filt(longint x, int base);
            longint y;
            y = clip(rnd_shift(longint'(cfg.coef_b0) * x + fmem[base], 16), -32768, 32767);
            fmem[base] = clip(longint'(cfg.coef_b1) * x - longint'(cfg.coef_a1) * y
                              + fmem[base + 1], -MEM_HI - 1, MEM_HI);
            fmem[base + 1] = clip(longint'(cfg.coef_b2) * x - longint'(cfg.coef_a2) * y,
                                  -MEM_HI - 1, MEM_HI);
            return y;
        endfunction

        function longint lerp(longint s0, longint s1, longint frac);
            return rnd_shift(s0 * 65536 + (s1 - s0) * frac, 16);
        endfunction

        function void write_reg(logic [2:0] idx, logic [17:0] d);
            case (idx)
                REG_FILTER_ENABLE: cfg.filter_enable = d[0];
                REG_COEF_B0:       cfg.coef_b0 = d;
                REG_COEF_B1:       cfg.coef_b1 = d;
                REG_COEF_B2:       cfg.coef_b2 = d;
                REG_COEF_A1:       cfg.coef_a1 = d;
                REG_COEF_A2:       cfg.coef_a2 = d;
                REG_SOURCE_STEREO: cfg.source_stereo = d[0];
                REG_OUTPUT_STEREO: cfg.output_stereo = d[0];
                default: ;
            endcase
        endfunction

        // Note an accepted input beat; queue the tick result it causes.
        function void note_input(in_item_t it);
            out_item_t r;
            int i0, i1;
            longint l, rr, yl, yr, nxt;
            bit done;
            r = '0;
            done = 0;
            case (it.opcode)
                OPC_WRITE: begin
                    lstore[it.sample_address] = it.sample_left;
                    rstore[it.sample_address] = it.sample_right;
                end
                OPC_START: begin
                    pos = {it.start_position, 16'd0};
                    endp = it.end_position;
                    pstep = it.pitch_step;
                    gain = it.note_gain > 32768 ? 32768 : it.note_gain;
                    rise = it.attack_step > 32768 ? 32768 : it.attack_step;
                    fall = it.release_step > 32768 ? 32768 : it.release_step;
                    if (fall == 0) fall = 32768;
                    attack = rise > 0;
                    release_on = 0;
                    level = attack ? 0 : 32768;
                    on = 1;
                    foreach (fmem[k]) fmem[k] = 0;
                end
                OPC_STOP_TAIL: if (on) begin
                    attack = 0;
                    release_on = 1;
                end
                OPC_STOP_NOW: begin
                    on = 0; attack = 0; release_on = 0;
                end
                OPC_TICK: begin
                    if (on) begin
                        i0 = pos[31:16];
                        i1 = (i0 + 1) % 65536;
                        l = lerp(lstore[i0], lstore[i1], pos[15:0]);
                        rr = cfg.source_stereo ? lerp(rstore[i0], rstore[i1], pos[15:0]) : l;
                        l = rnd_shift(rnd_shift(l * gain, 15) * level, 15);
                        rr = rnd_shift(rnd_shift(rr * gain, 15) * level, 15);
                        if (attack) begin
                            level += rise;
                            if (level >= 32768) begin
                                level = 32768;
                                attack = 0;
                            end
                        end else if (release_on) begin
                            level -= fall;
                            if (level <= 0) begin
                                level = 0;
                                on = 0;
                                release_on = 0;
                                done = 1;
                            end
                        end
                        if (!done) begin
                            if (cfg.output_stereo) begin
                                yl = cfg.filter_enable ? filt(l, 0) : l;
                                yr = cfg.filter_enable ? filt(rr, 2) : rr;
                            end else begin
                                yl = rnd_shift(l + rr, 1);
                                if (cfg.filter_enable) yl = filt(yl, 0);
                                yr = yl;
                            end
                            r.out_left = yl[15:0];
                            r.out_right = yr[15:0];
                            nxt = longint'(pos) + pstep;
                            pos = nxt > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : nxt[31:0];
                            if (nxt > (longint'(endp) <<< 16)) begin
                                on = 0; attack = 0; release_on = 0;
                            end
                            r.voice_active = on;
                        end
                    end
                    tick_queue.push_back(r);
                end
                default: ;
            endcase
        endfunction

        // Compare one result beat with the oldest prediction.
        function void check_result(out_item_t got);
            out_item_t want;
            if (tick_queue.size() == 0) begin
                $error("result beat with no tick pending: %h", got);
                errors++;
                return;
            end
            want = tick_queue.pop_front();
            if (got.out_left !== want.out_left) begin
                $error("out_left expected %0d actual %0d", want.out_left, got.out_left);
                errors++;
            end
            if (got.out_right !== want.out_right) begin
                $error("out_right expected %0d actual %0d", want.out_right, got.out_right);
                errors++;
            end
            if (got.voice_active !== want.voice_active) begin
                $error("voice_active expected %0d actual %0d",
                       want.voice_active, got.voice_active);
                errors++;
            end
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [17:0] cfg_data = '0;

    voice_scoreboard sb = new();
    int  burst_left = 0;
    bit  stall_on = 0;    // receiver stall pattern enable per phase

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sample_playback_voice_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Sample result beats at the rising edge; the check runs before the
    // falling edge moves m_ready.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // Receiver: stall in runs of random length while the pattern is enabled.
    int stall_run = 0;
    always @(negedge aclk) begin
        if (!stall_on) begin
            m_ready <= 1'b1;
        end else if (stall_run > 0) begin
            stall_run <= stall_run - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_run <= $urandom_range(1, 12);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Send one input beat; gap between random bursts, hold until accepted.
    // Valid stays high after the accept until the next beat, gap, register
    // write or drain replaces or drops it at the same falling edge.
    task automatic send_item(in_item_t it);
        int gap;
        cfg_valid <= 1'b0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(it);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [17:0] d);
        s_valid <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, d);
        @(negedge aclk);
    endtask

    // Hold until every predicted tick has drained, then let the block settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.tick_queue.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    function automatic in_item_t mk(logic [2:0] op);
        in_item_t it;
        it = '0;
        it.opcode = op;
        return it;
    endfunction

    task automatic send_write(int adr, logic [15:0] l, logic [15:0] r);
        in_item_t it;
        it = mk(OPC_WRITE);
        it.sample_address = 16'(adr);
        it.sample_left = l;
        it.sample_right = r;
        send_item(it);
    endtask

    task automatic send_start(int sp, int ep, int stp, int g, int att, int rel);
        in_item_t it;
        it = mk(OPC_START);
        it.start_position = 16'(sp);
        it.end_position = 16'(ep);
        it.pitch_step = 24'(stp);
        it.note_gain = 16'(g);
        it.attack_step = 16'(att);
        it.release_step = 16'(rel);
        send_item(it);
    endtask

    // Random item: mostly well-formed note play inside the written span;
    // occasional noise on every field (reads stay within written addresses).
    task automatic send_random();
        in_item_t it;
        int pick;
        it = in_item_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            it.opcode = OPC_TICK;
        end else if (pick < 76) begin
            it.opcode = OPC_START;
            it.start_position = 16'($urandom_range(0, STORE_SPAN - 2));
            it.end_position = $urandom_range(0, 3) == 0 ? 16'($urandom) :
                              16'($urandom_range(it.start_position, STORE_SPAN - 2));
            if ($urandom_range(0, 1)) it.pitch_step = 24'($urandom_range(0, 3 << 16));
            if ($urandom_range(0, 1)) it.attack_step = 16'($urandom_range(0, 4000));
            if ($urandom_range(0, 1)) it.release_step = 16'($urandom_range(0, 4000));
        end else if (pick < 80) begin
            it.opcode = OPC_STOP_TAIL;
        end else if (pick < 82) begin
            it.opcode = OPC_STOP_NOW;
        end else if (pick < 94) begin
            it.opcode = OPC_WRITE;
            if ($urandom_range(0, 1)) begin
                it.sample_address = 16'($urandom_range(0, STORE_SPAN - 1));
            end
        end else begin
            it.opcode = 3'($urandom_range(5, 7));
        end
        // An end point past the written span would let the play reach unwritten
        // entries; keep the read window inside the span.
        if (it.opcode == OPC_START && it.end_position > STORE_SPAN - 2) begin
            it.end_position = 16'(STORE_SPAN - 2);
        end
        send_item(it);
    endtask

    initial begin
        logic [17:0] coefs [5];
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Fill the played span and the two store edges for the wrap case.
        for (int a = 0; a < STORE_SPAN; a++) send_write(a, 16'($urandom), 16'($urandom));
        send_write(65535, 16'sh8000, 16'sh7fff);
        send_write(0, 16'sh7fff, 16'sh8000);

        // Directed: idle tick and stops, bad opcode, full-scale plays, wrap read.
        send_item(mk(OPC_TICK));
        send_item(mk(OPC_STOP_TAIL));
        send_item(mk(OPC_STOP_NOW));
        send_item(mk(3'd7));
        send_start(65535, 65535, 24'hFFFFFF, 16'hFFFF, 0, 0);     // wrap, overflow
        send_item(mk(OPC_TICK));
        send_item(mk(OPC_TICK));
        send_start(1, 100, 24'h008000, 32768, 16'hFFFF, 16'hFFFF); // oversized steps
        repeat (3) send_item(mk(OPC_TICK));
        send_item(mk(OPC_STOP_TAIL));                               // release in one tick
        send_item(mk(OPC_TICK));
        send_start(2, 2, 24'h004000, 20000, 9000, 0);               // end passed
        repeat (6) send_item(mk(OPC_TICK));
        send_start(10, 200, 24'h018000, 30000, 0, 11000);
        send_item(mk(OPC_TICK));
        send_start(20, 200, 24'h010000, 30000, 0, 11000);           // retrigger
        send_item(mk(OPC_TICK));
        send_item(mk(OPC_STOP_TAIL));
        repeat (4) send_item(mk(OPC_TICK));
        drain();

        // Random phases over register settings, extremes in phases 1 and 2.
        for (int ph = 0; ph < 8; ph++) begin
            stall_on = ph != 0;
            foreach (coefs[k]) begin
                case (ph)
                    1: coefs[k] = k == 0 ? 18'h1FFFF : 18'h20000;
                    2: coefs[k] = k == 0 ? 18'h20000 : 18'h1FFFF;
                    default: coefs[k] = $urandom_range(0, 3) == 0 ? 18'($urandom) :
                                        (k < 3 ? 18'($urandom_range(0, 30000)) : 18'd0);
                endcase
            end
            write_reg(REG_FILTER_ENABLE, 18'((ph % 3) != 0));
            write_reg(REG_COEF_B0, coefs[0]);
            write_reg(REG_COEF_B1, coefs[1]);
            write_reg(REG_COEF_B2, coefs[2]);
            write_reg(REG_COEF_A1, coefs[3]);
            write_reg(REG_COEF_A2, coefs[4]);
            write_reg(REG_SOURCE_STEREO, 18'(ph[0]));
            write_reg(REG_OUTPUT_STEREO, 18'(ph[1]));
            repeat (64) send_random();
            // Pause the sender until every tick beat has come back.
            drain();
        end

        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Limit: allow far more time than the slow path plus stalls needs.
    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end
endmodule
